FILE: sv/urfm_pkg.sv
// urfm_pkg: types and constants for the serial range frame monitor.
// Shared by urfm_parser and uart_range_frame_monitor; no dependencies.
package urfm_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int DIST_W     = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [CFG_DATA_W-1:0] MAX_AGE_RESET = 16'd200;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 1'b1;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [3:0] {
		POS_HUNT = 4'b0001,
		POS_HIGH = 4'b0010,
		POS_LOW  = 4'b0100,
		POS_SUM  = 4'b1000
	} pos_t;

	typedef struct packed {
		logic [DIST_W-1:0] range_mm;
		logic              fresh;
		logic              too_close;
		logic              frame_good;
		logic              frame_bad;
	} result_t;

	function automatic logic [OUT_DATA_W-1:0] pack_result(input result_t r);
		pack_result = {4'b0000, r.frame_bad, r.frame_good, r.too_close, r.fresh,
			r.range_mm};
	endfunction

endpackage

FILE: sv/urfm_parser.sv
// urfm_parser: frame hunt, checksum, held distance and age counter.
// Produces the result of each accepted transaction from the updated state.
// Depends on urfm_pkg.
module urfm_parser #(
	parameter int AGE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             req_type,
	input  logic [7:0]                       rx_byte,
	input  logic [urfm_pkg::CFG_DATA_W-1:0]  max_age,
	input  logic [urfm_pkg::CFG_DATA_W-1:0]  near_thr,
	output urfm_pkg::result_t                result
);

	localparam int CMP_W = (AGE_BITS > urfm_pkg::CFG_DATA_W) ? AGE_BITS : urfm_pkg::CFG_DATA_W;

	urfm_pkg::pos_t                  pos_q, pos_d;
	logic [7:0]                      hi_q, hi_d, lo_q, lo_d;
	logic [urfm_pkg::DIST_W-1:0]     dist_q, dist_d;
	logic [AGE_BITS-1:0]             age_q, age_d;
	logic                            seen_q, seen_d;
	logic                            good, bad;
	logic [7:0]                      sum;
	logic [CMP_W-1:0]                age_ext, max_ext;
	logic                            fresh;

	assign sum = urfm_pkg::START_BYTE + hi_q + lo_q;

	always_comb begin
		pos_d  = pos_q;
		hi_d   = hi_q;
		lo_d   = lo_q;
		dist_d = dist_q;
		age_d  = age_q;
		seen_d = seen_q;
		good   = 1'b0;
		bad    = 1'b0;
		if (req_type == urfm_pkg::REQ_TICK) begin
			if (age_q != {AGE_BITS{1'b1}}) begin
				age_d = age_q + 1'b1;
			end
		end else begin
			unique case (pos_q)
				urfm_pkg::POS_HUNT: begin
					if (rx_byte == urfm_pkg::START_BYTE) begin
						pos_d = urfm_pkg::POS_HIGH;
					end
				end
				urfm_pkg::POS_HIGH: begin
					hi_d  = rx_byte;
					pos_d = urfm_pkg::POS_LOW;
				end
				urfm_pkg::POS_LOW: begin
					lo_d  = rx_byte;
					pos_d = urfm_pkg::POS_SUM;
				end
				urfm_pkg::POS_SUM: begin
					pos_d = urfm_pkg::POS_HUNT;
					if (sum == rx_byte) begin
						dist_d = {hi_q, lo_q};
						age_d  = '0;
						seen_d = 1'b1;
						good   = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					pos_d = urfm_pkg::POS_HUNT;
				end
			endcase
		end
	end

	assign age_ext = CMP_W'(age_d);
	assign max_ext = CMP_W'(max_age);
	assign fresh   = seen_d && (age_ext <= max_ext);

	always_comb begin
		result.range_mm   = dist_d;
		result.fresh      = fresh;
		result.too_close  = fresh && (dist_d <= near_thr);
		result.frame_good = good;
		result.frame_bad  = bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= urfm_pkg::POS_HUNT;
			dist_q <= '0;
			age_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			pos_q  <= pos_d;
			dist_q <= dist_d;
			age_q  <= age_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
	end

endmodule

FILE: sv/uart_range_frame_monitor.sv
// uart_range_frame_monitor: top level with config registers and output buffer.
// Depends on urfm_pkg and urfm_parser.
//
//  channel  | direction | fields
//  ---------+-----------+-------------------------------------------------
//  s_*      | in        | tuser: req_type; tdata: rx_byte
//  m_*      | out       | tdata: range_mm, fresh, too_close, good, bad
//  cfg_*    | in        | index 0 max_age_ticks, 1 near_threshold_mm
//
// One transaction per cycle while s_tready is high; the parser state updates on each
// accepted transaction and its result is registered into the two-entry output buffer,
// which keeps s_tready high while one result waits on a stalled m_tready.
// Reset clears frame position, distance, age, seen flag and buffer valids.
module uart_range_frame_monitor #(
	parameter int AGE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	input  logic                                s_tuser,   // [0] req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] range_mm, [16] fresh, [17] too_close, [18] frame_good,
	// [19] frame_bad, [23:20] zero
	output logic [urfm_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [urfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [urfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [urfm_pkg::CFG_DATA_W-1:0]  max_age_q, near_q;
	logic                             accept;
	logic                             out_free;
	urfm_pkg::result_t                result;
	logic [urfm_pkg::OUT_DATA_W-1:0]  new_data;
	logic [urfm_pkg::OUT_DATA_W-1:0]  skid_data_q, out_data_q;
	logic                             skid_valid_q, out_valid_q;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign out_free = m_tready || !out_valid_q;
	assign new_data = urfm_pkg::pack_result(result);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= urfm_pkg::MAX_AGE_RESET;
			near_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urfm_pkg::REG_MAX_AGE: max_age_q <= cfg_wdata;
				urfm_pkg::REG_NEAR:    near_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	urfm_parser #(
		.AGE_BITS (AGE_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (s_tuser),
		.rx_byte  (s_tdata),
		.max_age  (max_age_q),
		.near_thr (near_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (accept) begin
				out_data_q <= new_data;
			end
		end else if (accept) begin
			skid_data_q <= new_data;
		end
	end

endmodule

FILE: sv/urfm_checker.sv
// urfm_checker: port-level assertions for uart_range_frame_monitor.
// Bound to the top level below; depends on urfm_pkg for the output width.
module urfm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [urfm_pkg::OUT_DATA_W-1:0]  m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_good_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
		else $error("frame good and bad together");

	a_close_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[16])
		else $error("too close without fresh");

	a_good_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> m_tdata[16])
		else $error("good frame not fresh");

endmodule

bind uart_range_frame_monitor urfm_checker u_urfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/tb_uart_range_frame_monitor.sv
// tb_uart_range_frame_monitor: self-checking bench for the serial range frame monitor.
// Uses urfm_pkg and uart_range_frame_monitor. Drives byte and tick transactions with
// random gaps and stalls, and checks every result against its own frame tracker.
module tb_uart_range_frame_monitor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AGE_BITS    = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 340;

	typedef struct {
		logic       kind;
		logic [7:0] data;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tuser = urfm_pkg::REQ_BYTE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [urfm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [urfm_pkg::CFG_IDX_W-1:0] cfg_index = urfm_pkg::REG_MAX_AGE;
	logic [urfm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	uart_range_frame_monitor #(.AGE_BITS(AGE_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rx_item_t rx_items[$];
	urfm_pkg::result_t expected_readings[$];
	int mismatches = 0;
	bit idle_on = 1'b1;
	bit in_fire = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	// frame tracker state
	urfm_pkg::pos_t frame_pos;
	logic [7:0] frame_hold [3];
	logic [urfm_pkg::DIST_W-1:0] held_mm;
	logic [AGE_BITS-1:0] sample_age;
	logic seen_meas;
	logic [urfm_pkg::CFG_DATA_W-1:0] max_age_lim;
	logic [urfm_pkg::CFG_DATA_W-1:0] near_lim;

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic track_frame(input logic kind, input logic [7:0] b,
			output urfm_pkg::result_t r);
		logic [7:0] chk;
		r = '0;
		if (kind == urfm_pkg::REQ_TICK) begin
			if (~&sample_age)
				sample_age = sample_age + 1'b1;
		end else begin
			case (frame_pos)
				urfm_pkg::POS_HUNT: begin
					if (b == urfm_pkg::START_BYTE) begin
						frame_hold[0] = b;
						frame_pos = urfm_pkg::POS_HIGH;
					end
				end
				urfm_pkg::POS_HIGH: begin
					frame_hold[1] = b;
					frame_pos = urfm_pkg::POS_LOW;
				end
				urfm_pkg::POS_LOW: begin
					frame_hold[2] = b;
					frame_pos = urfm_pkg::POS_SUM;
				end
				default: begin
					chk = frame_hold[0] + frame_hold[1] + frame_hold[2];
					frame_pos = urfm_pkg::POS_HUNT;
					if (chk == b) begin
						held_mm = {frame_hold[1], frame_hold[2]};
						sample_age = '0;
						seen_meas = 1'b1;
						r.frame_good = 1'b1;
					end else begin
						r.frame_bad = 1'b1;
					end
				end
			endcase
		end
		r.range_mm = held_mm;
		r.fresh = seen_meas && (sample_age <= max_age_lim);
		r.too_close = r.fresh && (held_mm <= near_lim);
	endtask

	always @(negedge clk) begin
		rx_item_t item;
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 14) - 1;
				s_tvalid <= 1'b0;
			end else if (rx_items.size() > 0) begin
				item = rx_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= item.kind;
				s_tdata <= item.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		urfm_pkg::result_t want;
		urfm_pkg::result_t got;
		in_fire = arst_n && s_tvalid && s_tready;
		if (in_fire) begin
			track_frame(s_tuser, s_tdata, want);
			expected_readings.push_back(want);
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.range_mm   = m_tdata[15:0];
			got.fresh      = m_tdata[16];
			got.too_close  = m_tdata[17];
			got.frame_good = m_tdata[18];
			got.frame_bad  = m_tdata[19];
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				want = expected_readings.pop_front();
				if (got.range_mm !== want.range_mm || got.fresh !== want.fresh ||
						got.too_close !== want.too_close ||
						got.frame_good !== want.frame_good ||
						got.frame_bad !== want.frame_bad)
					report_mismatch($sformatf(
						"dist %h/%h fresh %b/%b close %b/%b good %b/%b bad %b/%b (got/want)",
						got.range_mm, want.range_mm, got.fresh, want.fresh,
						got.too_close, want.too_close, got.frame_good, want.frame_good,
						got.frame_bad, want.frame_bad));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(input logic kind, input logic [7:0] data);
		rx_item_t item;
		item.kind = kind;
		item.data = data;
		rx_items.push_back(item);
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(urfm_pkg::REQ_TICK, 8'($urandom));
	endtask

	// one frame; returns the number of transactions queued
	task automatic push_frame(input logic [7:0] hi, input logic [7:0] lo, input bit good,
			input int tick_pct, output int n);
		logic [7:0] sum;
		logic [7:0] seq [4];
		int k;
		sum = urfm_pkg::START_BYTE + hi + lo;
		if (!good)
			sum = sum ^ (8'h01 << $urandom_range(0, 7));
		seq[0] = urfm_pkg::START_BYTE;
		seq[1] = hi;
		seq[2] = lo;
		seq[3] = sum;
		n = 0;
		for (int i = 0; i < 4; i++) begin
			if (i > 0 && $urandom_range(0, 99) < tick_pct) begin
				k = $urandom_range(1, 3);
				push_ticks(k);
				n += k;
			end
			push_item(urfm_pkg::REQ_BYTE, seq[i]);
			n++;
		end
	endtask

	task automatic write_reg(input logic [urfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [urfm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == urfm_pkg::REG_MAX_AGE)
			max_age_lim = val;
		else if (idx == urfm_pkg::REG_NEAR)
			near_lim = val;
	endtask

	task automatic wait_settled();
		while (rx_items.size() != 0 || s_tvalid || expected_readings.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic gen_traffic(input int n_items);
		int count;
		int n;
		int pick;
		logic [7:0] hi;
		count = 0;
		while (count < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				push_frame(hi, 8'($urandom), $urandom_range(0, 6) != 0, 20, n);
				count += n;
			end else if (pick < 75) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 40);
				push_ticks(n);
				count += n;
			end else if (pick < 88) begin
				n = $urandom_range(1, 3);
				repeat (n) push_item(urfm_pkg::REQ_BYTE, 8'($urandom));
				count += n;
			end else begin
				n = $urandom_range(0, 2);
				push_item(urfm_pkg::REQ_BYTE, urfm_pkg::START_BYTE);
				repeat (n) push_item(urfm_pkg::REQ_BYTE, 8'($urandom));
				count += n + 1;
			end
		end
	endtask

	initial begin
		int n;
		frame_pos = urfm_pkg::POS_HUNT;
		frame_hold[0] = '0;
		frame_hold[1] = '0;
		frame_hold[2] = '0;
		held_mm = '0;
		sample_age = '0;
		seen_meas = 1'b0;
		max_age_lim = urfm_pkg::MAX_AGE_RESET;
		near_lim = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: noise and tick before any frame, zero distance, 0xFF inside a frame,
		// tick in the middle of a frame, bad checksum, tick carrying 0xFF data
		push_item(urfm_pkg::REQ_BYTE, 8'h00);
		push_item(urfm_pkg::REQ_TICK, 8'h5A);
		push_frame(8'h00, 8'h00, 1'b1, 0, n);
		push_item(urfm_pkg::REQ_BYTE, urfm_pkg::START_BYTE);
		push_item(urfm_pkg::REQ_BYTE, 8'hFF);
		push_item(urfm_pkg::REQ_TICK, 8'h00);
		push_item(urfm_pkg::REQ_BYTE, 8'hFF);
		push_item(urfm_pkg::REQ_BYTE, 8'hFD);
		push_frame(8'h12, 8'h34, 1'b0, 0, n);
		push_item(urfm_pkg::REQ_TICK, urfm_pkg::START_BYTE);
		push_item(urfm_pkg::REQ_BYTE, 8'hFF);
		wait_settled();

		write_reg(urfm_pkg::REG_MAX_AGE, 16'h0000);
		write_reg(urfm_pkg::REG_NEAR, 16'hFFFF);
		push_frame(8'h12, 8'h34, 1'b1, 0, n);
		push_item(urfm_pkg::REQ_TICK, 8'hA5);
		push_item(urfm_pkg::REQ_BYTE, 8'h00);
		push_frame(8'hFF, 8'hFF, 1'b1, 0, n);
		wait_settled();

		// age runs past the limit, then a wider limit makes the reading fresh again
		idle_on = 1'b0;
		write_reg(urfm_pkg::REG_MAX_AGE, 16'd10);
		write_reg(urfm_pkg::REG_NEAR, 16'h0000);
		push_frame(8'h01, 8'h02, 1'b1, 0, n);
		push_ticks(40);
		wait_settled();
		write_reg(urfm_pkg::REG_MAX_AGE, 16'hFFFF);
		push_ticks(2);
		wait_settled();

		idle_on = 1'b1;
		write_reg(urfm_pkg::REG_MAX_AGE, 16'($urandom_range(0, 40)));
		write_reg(urfm_pkg::REG_NEAR, 16'($urandom));
		gen_traffic(PHASE_ITEMS);
		wait_settled();

		write_reg(urfm_pkg::REG_MAX_AGE, 16'h0000);
		write_reg(urfm_pkg::REG_NEAR, 16'hFFFF);
		gen_traffic(PHASE_ITEMS);
		wait_settled();

		idle_on = 1'b0;
		write_reg(urfm_pkg::REG_MAX_AGE, 16'hFFFF);
		write_reg(urfm_pkg::REG_NEAR, 16'($urandom_range(0, 1023)));
		gen_traffic(PHASE_ITEMS);
		wait_settled();

		idle_on = 1'b1;
		write_reg(urfm_pkg::REG_MAX_AGE, 16'($urandom));
		write_reg(urfm_pkg::REG_NEAR, 16'($urandom));
		gen_traffic(PHASE_ITEMS);
		wait_settled();

		idle_on = 1'b0;
		write_reg(urfm_pkg::REG_MAX_AGE, 16'($urandom_range(0, 60)));
		write_reg(urfm_pkg::REG_NEAR, 16'($urandom));
		gen_traffic(PHASE_ITEMS);
		wait_settled();

		repeat (5) @(negedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
